[hw/rtl/wpst_pkg.sv]
package wpst_pkg;

	// Field widths of the request and response words.
	localparam int OP_W      = 3;
	localparam int ID_W      = 32;
	localparam int WEIGHT_W  = 16;
	localparam int WORK_W    = 16;
	localparam int RUNS_W    = 32;
	localparam int SLOT_W    = 4;
	localparam int PEND_W    = 5;

	// Table size default and the cap on grants in one poll round.
	localparam int DEFAULT_SLOTS = 16;
	localparam int MAX_GRANTS    = 16;
	localparam int GRANT_W       = 5;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_CLEAR    = 3'd0;
	localparam logic [OP_W-1:0] OP_REGISTER = 3'd1;
	localparam logic [OP_W-1:0] OP_SCHEDULE = 3'd2;
	localparam logic [OP_W-1:0] OP_COMPLETE = 3'd3;
	localparam logic [OP_W-1:0] OP_POLL     = 3'd4;
	localparam logic [OP_W-1:0] OP_REPORT   = 3'd5;
	localparam logic [OP_W-1:0] OP_QUERY    = 3'd6;

	// Request word.
	typedef struct packed {
		logic [OP_W-1:0]     operation;
		logic [ID_W-1:0]     napi_id;
		logic [WEIGHT_W-1:0] weight;
		logic                handler_valid;
		logic [WORK_W-1:0]   work_done;
	} wpst_req_t;

	// Response word.
	typedef struct packed {
		logic                status;
		logic [ID_W-1:0]     id_out;
		logic [SLOT_W-1:0]   slot_out;
		logic [WEIGHT_W-1:0] grant_weight;
		logic [RUNS_W-1:0]   run_total;
		logic [PEND_W-1:0]   pending_count;
		logic                raise_softirq;
		logic                is_grant;
		logic                last;
	} wpst_rsp_t;

endpackage

[hw/rtl/weighted_poll_scheduler_table_core.sv]
// Weighted poll scheduler table: a table of NAPI_SLOTS poll contexts that
// can be registered, scheduled, completed, polled in rounds, credited with
// work reports and queried for run counts. Requests are taken one at a time.
// Every operation except clear all, a rejected register and an unknown code
// walks the table in slot order, reading the entry of each slot visited in
// state ST_RD and checking it in state ST_EV; this split is set by the single
// read port of the entry memory. Clear all, rejected registers and unknown
// codes answer with one word from state ST_ONE without walking the table.
// A poll round sends one response word per scheduled entry (up to sixteen),
// or one empty word; the last word of each request has last set. A stalled
// response channel holds the walk. After reset the table is empty at once.
module weighted_poll_scheduler_table_core #(
	parameter int NAPI_SLOTS = wpst_pkg::DEFAULT_SLOTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  wpst_pkg::wpst_req_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output wpst_pkg::wpst_rsp_t rsp
);
	import wpst_pkg::*;

	localparam int IDX_W = (NAPI_SLOTS > 1) ? $clog2(NAPI_SLOTS) : 1;
	localparam int CNT_W = $clog2(NAPI_SLOTS + 1);
	localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(NAPI_SLOTS - 1);
	localparam logic [IDX_W-1:0]   IDX_ONE   = IDX_W'(1);
	localparam logic [CNT_W-1:0]   CNT_ONE   = CNT_W'(1);
	localparam logic [GRANT_W-1:0] GRANT_ONE = GRANT_W'(1);
	localparam logic [GRANT_W-1:0] GRANT_CAP = GRANT_W'(MAX_GRANTS - 1);

	typedef struct packed {
		logic [ID_W-1:0]     ident;
		logic [WEIGHT_W-1:0] budget;
		logic [RUNS_W-1:0]   runs;
	} entry_t;

	typedef enum logic [1:0] {ST_IDLE, ST_RD, ST_EV, ST_ONE} state_t;

	state_t               state_q;
	wpst_req_t            op_q;
	logic [IDX_W-1:0]     idx_q;
	logic [GRANT_W-1:0]   grants_q;
	logic [GRANT_W-1:0]   reports_q;
	logic                 resched_q;
	logic [CNT_W-1:0]     pend_q;
	logic [ID_W-1:0]      next_id_q;
	logic [NAPI_SLOTS-1:0] used_q;
	logic [NAPI_SLOTS-1:0] sched_q;
	logic                 rsp_valid_q;
	wpst_rsp_t            rsp_q;
	entry_t               rd_q;
	entry_t               mem [NAPI_SLOTS];

	logic                 out_free;
	logic [NAPI_SLOTS-1:0] busy_vec;
	logic                 slot_used;
	logic                 slot_sched;
	logic                 match;
	logic [WEIGHT_W-1:0]  eff_budget;
	logic                 more_grants;
	logic [ID_W-1:0]      new_id;
	logic                 short_work;
	logic                 in_round;
	logic                 round_end;
	logic                 resched_nx;
	logic [CNT_W-1:0]     pend_up;
	logic [CNT_W-1:0]     pend_dn;
	logic                 emit;
	wpst_rsp_t            res;
	logic                 mem_we;
	entry_t               mem_wdata;
	logic                 scan_op;
	logic                 rsp_load;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Values derived from the entry under inspection.
	assign out_free    = !rsp_valid_q || rsp_ready;
	assign busy_vec    = used_q & sched_q;
	assign slot_used   = used_q[idx_q];
	assign slot_sched  = sched_q[idx_q];
	assign match       = slot_used && (rd_q.ident == op_q.napi_id);
	assign eff_budget  = (rd_q.budget == '0) ? WEIGHT_W'(1) : rd_q.budget;
	assign more_grants = |((busy_vec >> idx_q) >> 1);
	assign new_id      = (next_id_q == '0) ? ID_W'(1) : next_id_q;
	assign short_work  = (op_q.work_done < eff_budget);
	assign in_round    = (reports_q != '0);
	assign round_end   = (reports_q == GRANT_ONE);
	assign resched_nx  = resched_q | (!short_work && in_round);
	assign pend_up     = pend_q + CNT_ONE;
	assign pend_dn     = pend_q - CNT_ONE;

	// A new response word is loaded whenever a step emits and the register is free.
	assign rsp_load = out_free && (((state_q == ST_EV) && emit) || (state_q == ST_ONE));

	// Requests that walk the table; the rest answer with one word at once.
	always_comb begin
		unique case (req.operation)
			OP_REGISTER: scan_op = (req.weight != '0) && req.handler_valid;
			OP_SCHEDULE, OP_COMPLETE, OP_POLL, OP_REPORT, OP_QUERY: scan_op = 1'b1;
			default: scan_op = 1'b0;
		endcase
	end

	// Decide whether the current step sends a word, and build that word.
	always_comb begin
		emit = 1'b0;
		res = '0;
		res.pending_count = PEND_W'(pend_q);
		res.last = 1'b1;
		if (state_q == ST_ONE) begin
			emit = 1'b1;
			if (op_q.operation == OP_CLEAR) begin
				res.pending_count = '0;
			end else begin
				res.status = 1'b1;
			end
		end else if (state_q == ST_EV) begin
			unique case (op_q.operation)
				OP_REGISTER: begin
					if (!slot_used) begin
						emit = 1'b1;
						res.id_out = new_id;
						res.slot_out = SLOT_W'(idx_q);
					end else if (idx_q == LAST_IDX) begin
						emit = 1'b1;
						res.status = 1'b1;
					end
				end
				OP_POLL: begin
					if (slot_used && slot_sched) begin
						emit = 1'b1;
						res.is_grant = 1'b1;
						res.id_out = rd_q.ident;
						res.slot_out = SLOT_W'(idx_q);
						res.grant_weight = eff_budget;
						res.last = !more_grants || (grants_q == GRANT_CAP);
					end else if (idx_q == LAST_IDX) begin
						emit = 1'b1;
					end
				end
				OP_SCHEDULE, OP_COMPLETE, OP_REPORT, OP_QUERY: begin
					if (match) begin
						emit = 1'b1;
						if (op_q.operation != OP_QUERY) begin
							res.slot_out = SLOT_W'(idx_q);
						end
						if (op_q.operation == OP_SCHEDULE) begin
							res.raise_softirq = 1'b1;
							res.pending_count = PEND_W'(slot_sched ? pend_q : pend_up);
						end else if (op_q.operation == OP_COMPLETE) begin
							res.pending_count = PEND_W'(slot_sched ? pend_dn : pend_q);
						end else if (op_q.operation == OP_REPORT) begin
							res.raise_softirq = round_end && resched_nx;
							res.pending_count =
								PEND_W'((short_work && slot_sched) ? pend_dn : pend_q);
						end else begin
							res.run_total = rd_q.runs;
						end
					end else if (idx_q == LAST_IDX) begin
						emit = 1'b1;
						res.status = 1'b1;
					end
				end
				default: begin
					emit = 1'b1;
					res.status = 1'b1;
				end
			endcase
		end
	end

	// Entry memory write data: a new entry on register, a run count bump on report.
	always_comb begin
		mem_we = (state_q == ST_EV) && emit && out_free && !res.status &&
			((op_q.operation == OP_REGISTER) || (op_q.operation == OP_REPORT));
		if (op_q.operation == OP_REGISTER) begin
			mem_wdata.ident  = new_id;
			mem_wdata.budget = op_q.weight;
			mem_wdata.runs   = '0;
		end else begin
			mem_wdata.ident  = rd_q.ident;
			mem_wdata.budget = rd_q.budget;
			mem_wdata.runs   = rd_q.runs + RUNS_W'(1);
		end
	end

	// Entry memory with one registered read port and one write port.
	always_ff @(posedge clk) begin
		rd_q <= mem[idx_q];
		if (mem_we) begin
			mem[idx_q] <= mem_wdata;
		end
	end

	// Sequencer, slot flags, round accounting and the response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= '0;
			idx_q       <= '0;
			grants_q    <= '0;
			reports_q   <= '0;
			resched_q   <= 1'b0;
			pend_q      <= '0;
			next_id_q   <= ID_W'(1);
			used_q      <= '0;
			sched_q     <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						op_q     <= req;
						idx_q    <= '0;
						grants_q <= '0;
						state_q  <= scan_op ? ST_RD : ST_ONE;
					end
				end
				ST_RD: begin
					state_q <= ST_EV;
				end
				ST_EV: begin
					if (!emit) begin
						idx_q   <= idx_q + IDX_ONE;
						state_q <= ST_RD;
					end else if (out_free) begin
						rsp_q <= res;
						if (!res.status) begin
							unique case (op_q.operation)
								OP_REGISTER: begin
									used_q[idx_q]  <= 1'b1;
									sched_q[idx_q] <= 1'b0;
									next_id_q      <= new_id + ID_W'(1);
								end
								OP_SCHEDULE: begin
									sched_q[idx_q] <= 1'b1;
									if (!slot_sched) begin
										pend_q <= pend_up;
									end
								end
								OP_COMPLETE: begin
									sched_q[idx_q] <= 1'b0;
									if (slot_sched) begin
										pend_q <= pend_dn;
									end
								end
								OP_REPORT: begin
									if (short_work) begin
										sched_q[idx_q] <= 1'b0;
										if (slot_sched) begin
											pend_q <= pend_dn;
										end
									end
									if (in_round) begin
										reports_q <= reports_q - GRANT_ONE;
									end
									resched_q <= round_end ? 1'b0 : resched_nx;
								end
								OP_POLL: begin
									if (res.is_grant) begin
										grants_q <= grants_q + GRANT_ONE;
										if (res.last) begin
											reports_q <= grants_q + GRANT_ONE;
											resched_q <= 1'b0;
										end
									end else begin
										reports_q <= '0;
										resched_q <= 1'b0;
									end
								end
								default: begin
								end
							endcase
						end
						if (res.last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + IDX_ONE;
							state_q <= ST_RD;
						end
					end
				end
				ST_ONE: begin
					if (out_free) begin
						rsp_q   <= res;
						state_q <= ST_IDLE;
						if (op_q.operation == OP_CLEAR) begin
							used_q    <= '0;
							sched_q   <= '0;
							next_id_q <= ID_W'(1);
							reports_q <= '0;
							resched_q <= 1'b0;
							pend_q    <= '0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[hw/rtl/wpst_checker.sv]
// Port-level checks for the poll scheduler table.
module wpst_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input wpst_pkg::wpst_req_t req,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input wpst_pkg::wpst_rsp_t rsp
);
	import wpst_pkg::*;

	// A held response word stays put until it is taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response word changed while stalled");

	// The block works on one request at a time.
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in progress");

	// An error word is always the only word of its request.
	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status |-> rsp.last && !rsp.is_grant && !rsp.raise_softirq)
		else $error("error word with grant, softirq or missing last");

	// A grant always carries a nonzero budget and an identifier.
	a_grant_word: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.is_grant |-> rsp.grant_weight != '0 && rsp.id_out != '0)
		else $error("grant word without budget or identifier");

endmodule

bind weighted_poll_scheduler_table_core wpst_checker u_wpst_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

[verif/tb_weighted_poll_scheduler_table_core.sv]
module tb_weighted_poll_scheduler_table_core;
	import wpst_pkg::*;

	localparam int SLOTS = DEFAULT_SLOTS;
	localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
	localparam int LONG_HOLD = 300;
	localparam int DIRECTED_ITEMS = 25;
	localparam int RANDOM_ITEMS = 280;
	localparam int SHOW_LIMIT = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	wpst_req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	wpst_rsp_t rsp;

	weighted_poll_scheduler_table_core #(
		.NAPI_SLOTS(SLOTS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	// Free-running clock with a period of 10.
	always #5 clk = ~clk;

	// Predicted contents of the poll table and the round bookkeeping.
	logic                ctx_used [SLOTS];
	logic                ctx_sched [SLOTS];
	logic [ID_W-1:0]     ctx_id [SLOTS];
	logic [WEIGHT_W-1:0] ctx_budget [SLOTS];
	logic [RUNS_W-1:0]   ctx_runs [SLOTS];
	logic [ID_W-1:0]     ident_next;
	int unsigned         reports_left;
	logic                budget_exhausted;

	// Request words waiting to be sent and response words still owed by the block.
	wpst_req_t request_q [$];
	wpst_rsp_t predicted_rsp_q [$];

	int unsigned queued_cnt = 0;
	int unsigned taken_cnt = 0;
	int unsigned words_seen = 0;
	int unsigned grants_seen = 0;
	int unsigned raises_seen = 0;
	int unsigned mismatches = 0;
	int unsigned op_count [8];

	int  send_idle = 0;
	bit  send_burst = 1'b0;
	bit  send_offer;
	int  take_hold = 0;
	bit  take_burst = 1'b0;
	bit  take_ready;

	function automatic void clear_contexts();
		int i;
		for (i = 0; i < SLOTS; i++) begin
			ctx_used[i] = 1'b0;
			ctx_sched[i] = 1'b0;
			ctx_id[i] = '0;
			ctx_budget[i] = '0;
			ctx_runs[i] = '0;
		end
		ident_next = 32'd1;
		reports_left = 0;
		budget_exhausted = 1'b0;
	endfunction

	function automatic int find_ctx(input logic [ID_W-1:0] id);
		int i;
		for (i = 0; i < SLOTS; i++) begin
			if (ctx_used[i] && ctx_id[i] == id)
				return i;
		end
		return -1;
	endfunction

	// A zero budget still allows one unit of work.
	function automatic logic [WEIGHT_W-1:0] grant_budget(input int s);
		return (ctx_budget[s] == '0) ? 16'd1 : ctx_budget[s];
	endfunction

	function automatic logic [PEND_W-1:0] count_pending();
		logic [PEND_W-1:0] n;
		int i;
		n = '0;
		for (i = 0; i < SLOTS; i++) begin
			if (ctx_used[i] && ctx_sched[i])
				n = n + 5'd1;
		end
		return n;
	endfunction

	// Work out the response words of one accepted request and queue them.
	function automatic void predict_scheduler_step(input wpst_req_t r);
		wpst_rsp_t words [$];
		wpst_rsp_t w;
		logic [ID_W-1:0] id;
		logic [PEND_W-1:0] npend;
		int s;
		int i;
		w = '0;
		w.status = 1'b1;
		s = -1;
		case (r.operation)
			OP_CLEAR: begin
				clear_contexts();
				w.status = 1'b0;
			end
			OP_REGISTER: begin
				if (r.weight != '0 && r.handler_valid) begin
					for (i = 0; i < SLOTS; i++) begin
						if (!ctx_used[i] && s < 0)
							s = i;
					end
					if (s >= 0) begin
						// Identifier zero is reserved, so the counter skips it on wrap.
						id = ident_next;
						ident_next = ident_next + 32'd1;
						if (id == '0) begin
							id = ident_next;
							ident_next = ident_next + 32'd1;
						end
						ctx_used[s] = 1'b1;
						ctx_sched[s] = 1'b0;
						ctx_id[s] = id;
						ctx_budget[s] = r.weight;
						ctx_runs[s] = '0;
						w.status = 1'b0;
						w.id_out = id;
						w.slot_out = SLOT_W'(s);
					end
				end
			end
			OP_SCHEDULE: begin
				s = find_ctx(r.napi_id);
				if (s >= 0) begin
					ctx_sched[s] = 1'b1;
					w.status = 1'b0;
					w.slot_out = SLOT_W'(s);
					w.raise_softirq = 1'b1;
				end
			end
			OP_COMPLETE: begin
				s = find_ctx(r.napi_id);
				if (s >= 0) begin
					ctx_sched[s] = 1'b0;
					w.status = 1'b0;
					w.slot_out = SLOT_W'(s);
				end
			end
			OP_POLL: begin
				// A new round replaces any round still waiting for reports.
				for (i = 0; i < SLOTS; i++) begin
					if (ctx_used[i] && ctx_sched[i] && words.size() < MAX_GRANTS) begin
						w = '0;
						w.id_out = ctx_id[i];
						w.slot_out = SLOT_W'(i);
						w.grant_weight = grant_budget(i);
						w.is_grant = 1'b1;
						words.push_back(w);
					end
				end
				reports_left = words.size();
				budget_exhausted = 1'b0;
				w = '0;
			end
			OP_REPORT: begin
				s = find_ctx(r.napi_id);
				if (s >= 0) begin
					ctx_runs[s] = ctx_runs[s] + 32'd1;
					if (r.work_done < grant_budget(s))
						ctx_sched[s] = 1'b0;
					else if (reports_left > 0)
						budget_exhausted = 1'b1;
					// Only reports inside a round move the round accounting.
					if (reports_left > 0) begin
						reports_left--;
						if (reports_left == 0) begin
							w.raise_softirq = budget_exhausted;
							budget_exhausted = 1'b0;
						end
					end
					w.status = 1'b0;
					w.slot_out = SLOT_W'(s);
				end
			end
			OP_QUERY: begin
				s = find_ctx(r.napi_id);
				if (s >= 0) begin
					w.status = 1'b0;
					w.run_total = ctx_runs[s];
				end
			end
			default: begin
			end
		endcase
		if (words.size() == 0)
			words.push_back(w);
		npend = count_pending();
		foreach (words[k]) begin
			words[k].pending_count = npend;
			words[k].last = (k == words.size() - 1);
			predicted_rsp_q.push_back(words[k]);
		end
	endfunction

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= SHOW_LIMIT)
				$display("%0t: %s expected %h got %h", $time, name, want, got);
		end
	endfunction

	// Check one response word against the oldest predicted word.
	function automatic void check_rsp_word(input wpst_rsp_t got);
		wpst_rsp_t want;
		if (got.is_grant)
			grants_seen++;
		if (got.raise_softirq)
			raises_seen++;
		if (predicted_rsp_q.size() == 0) begin
			mismatches++;
			if (mismatches <= SHOW_LIMIT)
				$display("%0t: response word %h with nothing outstanding", $time, got);
		end else begin
			want = predicted_rsp_q.pop_front();
			compare_field("status", 32'(want.status), 32'(got.status));
			compare_field("id_out", want.id_out, got.id_out);
			compare_field("slot_out", 32'(want.slot_out), 32'(got.slot_out));
			compare_field("grant_weight", 32'(want.grant_weight), 32'(got.grant_weight));
			compare_field("run_total", want.run_total, got.run_total);
			compare_field("pending_count", 32'(want.pending_count), 32'(got.pending_count));
			compare_field("raise_softirq", 32'(want.raise_softirq), 32'(got.raise_softirq));
			compare_field("is_grant", 32'(want.is_grant), 32'(got.is_grant));
			compare_field("last", 32'(want.last), 32'(got.last));
		end
	endfunction

	// Request driver: offers queued words, predicting each one as it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			send_idle = 0;
		end else begin
			send_offer = req_valid;
			if (req_valid && req_ready) begin
				predict_scheduler_step(req);
				op_count[req.operation]++;
				taken_cnt++;
				send_offer = 1'b0;
				if ($urandom_range(0, 19) == 0)
					send_burst = !send_burst;
				send_idle = send_burst ? 0 : $urandom_range(0, 10);
			end
			if (!send_offer) begin
				if (send_idle > 0) begin
					send_idle--;
				end else if (request_q.size() > 0) begin
					req <= request_q.pop_front();
					send_offer = 1'b1;
				end
			end
			req_valid <= send_offer;
		end
	end

	// Response monitor: random back-pressure, with two long holds during the run.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			take_hold = 0;
		end else begin
			take_ready = rsp_ready;
			if (rsp_valid && rsp_ready) begin
				check_rsp_word(rsp);
				words_seen++;
				take_ready = 1'b0;
				if ($urandom_range(0, 19) == 0)
					take_burst = !take_burst;
				take_hold = take_burst ? 0 : $urandom_range(0, 10);
				if (words_seen == 120 || words_seen == 400)
					take_hold = LONG_HOLD;
			end
			if (!take_ready) begin
				if (take_hold > 0)
					take_hold--;
				else
					take_ready = 1'b1;
			end
			rsp_ready <= take_ready;
		end
	end

	function automatic void queue_req(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
			input logic [WEIGHT_W-1:0] wt, input logic hv, input logic [WORK_W-1:0] work);
		wpst_req_t r;
		r.operation = op;
		r.napi_id = id;
		r.weight = wt;
		r.handler_valid = hv;
		r.work_done = work;
		request_q.push_back(r);
		queued_cnt++;
	endfunction

	// Mostly small budgets so that work reports land on both sides of them.
	function automatic logic [WEIGHT_W-1:0] pick_weight();
		int sel;
		sel = $urandom_range(0, 11);
		case (sel)
			0: return '0;
			1: return 16'd1;
			2: return '1;
			3, 4: return WEIGHT_W'($urandom_range(1, 65535));
			default: return WEIGHT_W'($urandom_range(1, 64));
		endcase
	endfunction

	function automatic logic [WORK_W-1:0] pick_work(input logic [WEIGHT_W-1:0] budget);
		logic [WEIGHT_W-1:0] eff;
		int sel;
		eff = (budget == '0) ? 16'd1 : budget;
		sel = $urandom_range(0, 6);
		case (sel)
			0: return '0;
			1: return eff - 16'd1;
			2: return eff;
			3: return '1;
			4: return (eff > 16'hFFEB) ? '1 : eff + WORK_W'($urandom_range(1, 20));
			5: return WORK_W'($urandom_range(0, 32'(eff)));
			default: return WORK_W'($urandom());
		endcase
	endfunction

	// Hold the sender back until every word owed by the block has come.
	task automatic settle();
		while (taken_cnt != queued_cnt || predicted_rsp_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Directed opening: empty table, bad arguments, a full round and its reports.
	function automatic void queue_directed();
		queue_req(OP_QUERY, 32'd1, '0, 1'b0, '0);
		queue_req(OP_POLL, '0, '0, 1'b0, '0);
		queue_req(OP_REGISTER, '0, 16'd0, 1'b1, '0);
		queue_req(OP_REGISTER, '0, 16'd5, 1'b0, '0);
		queue_req(OP_REGISTER, '0, 16'd1, 1'b1, '0);
		queue_req(OP_REGISTER, '1, '1, 1'b1, '1);
		queue_req(OP_REGISTER, '0, 16'd3, 1'b1, '0);
		queue_req(OP_SCHEDULE, 32'd1, '0, 1'b0, '0);
		queue_req(OP_SCHEDULE, 32'd2, '0, 1'b0, '0);
		queue_req(OP_SCHEDULE, 32'd3, '0, 1'b0, '0);
		queue_req(OP_SCHEDULE, 32'd0, '0, 1'b0, '0);
		queue_req(OP_COMPLETE, 32'd3, '0, 1'b0, '0);
		queue_req(OP_POLL, '0, '0, 1'b0, '0);
		queue_req(OP_REPORT, 32'd1, '0, 1'b0, 16'd0);
		queue_req(OP_REPORT, 32'd2, '0, 1'b0, '1);
		queue_req(OP_REPORT, 32'd3, '0, 1'b0, 16'd7);
		queue_req(OP_POLL, '0, '0, 1'b0, '0);
		queue_req(OP_POLL, '0, '0, 1'b0, '0);
		queue_req(OP_REPORT, 32'd2, '0, 1'b0, 16'd100);
		queue_req(OP_QUERY, 32'd2, '0, 1'b0, '0);
		queue_req(OP_COMPLETE, '1, '0, 1'b0, '0);
		queue_req(OP_UNUSED, '1, '1, 1'b1, '1);
		queue_req(OP_REPORT, 32'd77, '0, 1'b0, 16'd5);
		queue_req(OP_CLEAR, '0, '0, 1'b0, '0);
		queue_req(OP_QUERY, 32'd1, '0, 1'b0, '0);
	endfunction

	// One random phase, built from the predicted table as it stands now.
	task automatic random_phase();
		int live [$];
		int granted [$];
		logic view [SLOTS];
		int i;
		int n;
		int s;
		logic [OP_W-1:0] op;
		logic [ID_W-1:0] id;
		for (i = 0; i < SLOTS; i++) begin
			view[i] = ctx_used[i] && ctx_sched[i];
			if (ctx_used[i])
				live.push_back(i);
		end
		if (live.size() < 4 || $urandom_range(0, 9) == 0) begin
			// Register a batch, at times more than the free slots can hold.
			n = $urandom_range(1, SLOTS + 2 - live.size());
			for (i = 0; i < n; i++)
				queue_req(OP_REGISTER, $urandom(), pick_weight(),
					1'($urandom_range(0, 9) != 0), WORK_W'($urandom()));
		end else if ($urandom_range(0, 7) == 0) begin
			// Noise: any operation, known or random identifiers, rare clears.
			for (i = 0; i < 8; i++) begin
				op = OP_W'($urandom_range(0, 7));
				if (op == OP_CLEAR && $urandom_range(0, 2) != 0)
					op = OP_QUERY;
				id = ($urandom_range(0, 1) == 0) ? $urandom()
					: ctx_id[live[$urandom_range(0, live.size() - 1)]];
				queue_req(op, id, WEIGHT_W'($urandom()), 1'($urandom_range(0, 1)),
					WORK_W'($urandom()));
			end
		end else begin
			// A poll round: mark entries, poll, then answer the grants.
			if ($urandom_range(0, 5) == 0) begin
				foreach (live[k]) begin
					queue_req(OP_SCHEDULE, ctx_id[live[k]], '0, 1'b0, '0);
					view[live[k]] = 1'b1;
				end
			end else begin
				n = $urandom_range(1, 6);
				for (i = 0; i < n; i++) begin
					s = live[$urandom_range(0, live.size() - 1)];
					if ($urandom_range(0, 9) < 7) begin
						queue_req(OP_SCHEDULE, ctx_id[s], '0, 1'b0, '0);
						view[s] = 1'b1;
					end else begin
						queue_req(OP_COMPLETE, ctx_id[s], '0, 1'b0, '0);
						view[s] = 1'b0;
					end
				end
			end
			queue_req(OP_POLL, '0, '0, 1'b0, '0);
			for (i = 0; i < SLOTS; i++) begin
				if (view[i])
					granted.push_back(i);
			end
			foreach (granted[k]) begin
				if (k > 0 && $urandom_range(0, 19) == 0)
					queue_req(OP_POLL, '0, '0, 1'b0, '0);
				if ($urandom_range(0, 11) != 0)
					queue_req(OP_REPORT, ctx_id[granted[k]], '0, 1'b0,
						pick_work(ctx_budget[granted[k]]));
			end
			if ($urandom_range(0, 3) == 0) begin
				s = live[$urandom_range(0, live.size() - 1)];
				queue_req(OP_REPORT, ctx_id[s], '0, 1'b0, pick_work(ctx_budget[s]));
			end
			n = $urandom_range(0, 2);
			for (i = 0; i < n; i++) begin
				id = ($urandom_range(0, 7) == 0) ? $urandom()
					: ctx_id[live[$urandom_range(0, live.size() - 1)]];
				queue_req(OP_QUERY, id, '0, 1'b0, '0);
			end
		end
		settle();
	endtask

	// Main sequence: reset, directed words, random phases, then the verdict.
	initial begin
		clear_contexts();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		queue_directed();
		settle();
		while (queued_cnt < DIRECTED_ITEMS + RANDOM_ITEMS)
			random_phase();
		settle();
		repeat (60) @(posedge clk);
		$display("Run covered %0d requests (%0d registers, %0d schedules, %0d polls, %0d reports,",
			taken_cnt, op_count[OP_REGISTER], op_count[OP_SCHEDULE], op_count[OP_POLL],
			op_count[OP_REPORT]);
		$display("%0d queries, %0d clears) and %0d response words with %0d grants, %0d raises.",
			op_count[OP_QUERY], op_count[OP_CLEAR], words_seen, grants_seen, raises_seen);
		if (mismatches == 0 && predicted_rsp_q.size() == 0) begin
			$display("tb_weighted_poll_scheduler_table_core: clean");
		end else begin
			$display("%0d mismatches, %0d words still owed", mismatches, predicted_rsp_q.size());
			$display("tb_weighted_poll_scheduler_table_core: errors");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#5000000;
		$display("tb_weighted_poll_scheduler_table_core: errors");
		$finish;
	end

endmodule
